// File: design/lts_pkg.sv
package lts_pkg;

  // command codes
  localparam logic [1:0] CMD_PACKET     = 2'd0;
  localparam logic [1:0] CMD_READ_PROTO = 2'd1;
  localparam logic [1:0] CMD_READ_SLOT  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_COUNTED  = 2'd0;
  localparam logic [1:0] STAT_IGNORED  = 2'd1;
  localparam logic [1:0] STAT_READ_OK  = 2'd2;
  localparam logic [1:0] STAT_READ_BAD = 2'd3;

  // protocol classes
  localparam logic [1:0] CLS_TCP   = 2'd0;
  localparam logic [1:0] CLS_UDP   = 2'd1;
  localparam logic [1:0] CLS_ICMP  = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  localparam logic [7:0] LOOPBACK_OCTET    = 8'd127;
  localparam logic [3:0] IPV4_VERSION      = 4'd4;
  localparam logic [6:0] MAX_ENTRIES_RESET = 7'd50;
  localparam logic [5:0] TOTAL_INDEX       = 6'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PKT,
    ST_PBYTE,
    ST_SEARCH,
    ST_HIT_CNT,
    ST_HIT_BYTE,
    ST_MISS,
    ST_TOTAL,
    ST_SLOT_RD,
    ST_SLOT_WAIT,
    ST_RESP
  } st_e;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] src_hits;
    logic [31:0] dst_hits;
    logic [47:0] byte_count;
  } slot_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  proto_class;
    logic        address_dropped;
    logic [6:0]  entries_in_use;
    logic [31:0] read_addr;
    logic [31:0] read_count_a;
    logic [31:0] read_count_b;
    logic [47:0] read_bytes;
  } res_t;

  function automatic logic is_loopback(input logic [31:0] addr);
    return addr[31:24] == LOOPBACK_OCTET;
  endfunction

  function automatic logic [1:0] classify(input logic [7:0] proto);
    logic [1:0] cls;
    priority if (proto == PROTO_TCP) begin
      cls = CLS_TCP;
    end else if (proto == PROTO_UDP) begin
      cls = CLS_UDP;
    end else if (proto == PROTO_ICMP) begin
      cls = CLS_ICMP;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

// File: design/lts_req_if.sv
interface lts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  ip_version;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  protocol;
  logic [15:0] pkt_len;
  logic [5:0]  read_index;

  modport source (
    output valid, command, ip_version, src_addr, dst_addr, protocol, pkt_len, read_index,
    input  ready
  );
  modport sink (
    input  valid, command, ip_version, src_addr, dst_addr, protocol, pkt_len, read_index,
    output ready
  );
endinterface

// File: design/lts_rsp_if.sv
interface lts_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  proto_class;
  logic        address_dropped;
  logic [6:0]  entries_in_use;
  logic [31:0] read_addr;
  logic [31:0] read_count_a;
  logic [31:0] read_count_b;
  logic [47:0] read_bytes;

  modport source (
    output valid, status, proto_class, address_dropped, entries_in_use,
           read_addr, read_count_a, read_count_b, read_bytes,
    input  ready
  );
  modport sink (
    input  valid, status, proto_class, address_dropped, entries_in_use,
           read_addr, read_count_a, read_count_b, read_bytes,
    output ready
  );
endinterface

// File: design/loopback_traffic_stats_table_top.sv
// loopback traffic statistics table: takes one request at a time on req_i (a packet header
// summary or a read) and returns exactly one response on rsp_o. an ipv4 packet with a
// 127.x.x.x source or destination bumps one of four protocol counters and then looks its
// loopback addresses up in an address table, source first; a miss fills the next slot
// while fewer than max_entries (cfg_wdata_i, reset 50, capped at TABLE_DEPTH) are in use,
// otherwise the address is dropped and flagged. the table lives in a single-port-read
// memory scanned one slot per cycle by a small sequencer, and all packet, byte and hit
// counter updates go through one shared 48-bit adder. a counted packet first bumps its
// packet counter, then its byte counter, then scans the table for each loopback address;
// a hit bumps the slot's hit count, then adds the length and writes the slot back. a total
// read sums the four packet counters, then the four byte counters. the memory read port
// sets the scan rate. req_i is ready only while the sequencer is idle; a finished response
// waits in the output register, so the next request can already be taken while rsp_o is
// stalled. the table needs no clearing after reset: only slots below the fill count are
// ever read.
module loopback_traffic_stats_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  lts_req_if.sink    req_i,
  lts_rsp_if.source  rsp_o
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int LimW = (CntW > 7) ? CntW : 7;

  // sequencer and control state
  lts_pkg::st_e    state_q, state_d;
  logic [CntW-1:0] used_q;
  logic [6:0]      max_q;
  logic            phase_q;          // 0 source lookup, 1 destination lookup
  logic [CntW-1:0] scan_q;
  logic            iss_vld_q;
  logic [IdxW-1:0] iss_idx_q;
  logic [2:0]      k_q;
  logic            out_valid_q;

  // protocol counters
  logic [31:0] pkt_q  [4];
  logic [47:0] byte_q [4];

  // latched request and working data
  logic [31:0]    src_q, dst_q;
  logic [15:0]    len_q;
  logic [1:0]     cls_q;
  logic [5:0]     idx_q;
  logic [IdxW-1:0] hit_idx_q;
  lts_pkg::slot_t entry_q;
  lts_pkg::res_t  res_q, res_init, res_fin, out_q;

  // address table memory
  lts_pkg::slot_t slot_mem_q [TABLE_DEPTH];
  lts_pkg::slot_t rd_q;

  // shared adder and memory controls
  logic [47:0]     add_a, add_b, add_sum;
  logic [IdxW-1:0] rd_idx, mem_widx;
  logic            mem_we, issue;
  lts_pkg::slot_t  mem_wdata;

  // derived conditions
  logic            accept, can_send, full, match, src_lb, dst_lb, req_counted, req_slot_ok;
  logic [31:0]     key;
  logic [LimW-1:0] used_ext, idx_ext, req_idx_ext;
  logic [IdxW-1:0] slot_idx;

  assign accept   = req_i.valid && req_i.ready;
  assign can_send = !out_valid_q || rsp_o.ready;
  assign add_sum  = add_a + add_b;

  assign used_ext    = LimW'(used_q);
  assign idx_ext     = LimW'(idx_q);
  assign req_idx_ext = LimW'(req_i.read_index);
  assign slot_idx    = idx_ext[IdxW-1:0];
  // limit is the smaller of max_entries and the table depth
  assign full        = (used_ext >= LimW'(max_q)) || (used_q == CntW'(TABLE_DEPTH));

  assign src_lb = lts_pkg::is_loopback(src_q);
  assign dst_lb = lts_pkg::is_loopback(dst_q);
  assign key    = phase_q ? dst_q : src_q;
  assign match  = iss_vld_q && (rd_q.addr == key);

  assign req_counted = (req_i.command == lts_pkg::CMD_PACKET) &&
                       (req_i.ip_version == lts_pkg::IPV4_VERSION) &&
                       (lts_pkg::is_loopback(req_i.src_addr) ||
                        lts_pkg::is_loopback(req_i.dst_addr));
  assign req_slot_ok = (req_i.command == lts_pkg::CMD_READ_SLOT) && (req_idx_ext < used_ext);

  // initial response fields, decided when the request is taken
  always_comb begin
    res_init        = '0;
    res_init.status = lts_pkg::STAT_IGNORED;
    priority if (req_counted) begin
      res_init.status      = lts_pkg::STAT_COUNTED;
      res_init.proto_class = lts_pkg::classify(req_i.protocol);
    end else if (req_i.command == lts_pkg::CMD_READ_PROTO) begin
      priority if (req_i.read_index < lts_pkg::TOTAL_INDEX) begin
        res_init.status       = lts_pkg::STAT_READ_OK;
        res_init.read_count_a = pkt_q[req_i.read_index[1:0]];
        res_init.read_bytes   = byte_q[req_i.read_index[1:0]];
      end else if (req_i.read_index == lts_pkg::TOTAL_INDEX) begin
        res_init.status = lts_pkg::STAT_READ_OK;
      end else begin
        res_init.status = lts_pkg::STAT_READ_BAD;
      end
    end else if (req_i.command == lts_pkg::CMD_READ_SLOT) begin
      res_init.status = req_slot_ok ? lts_pkg::STAT_READ_OK : lts_pkg::STAT_READ_BAD;
    end else begin
      res_init.status = lts_pkg::STAT_IGNORED;
    end
  end

  // finished response with the fill count after this request
  always_comb begin
    res_fin                = res_q;
    res_fin.entries_in_use = 7'(used_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lts_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (req_counted) begin
            state_d = lts_pkg::ST_PKT;
          end else if ((req_i.command == lts_pkg::CMD_READ_PROTO) &&
                       (req_i.read_index == lts_pkg::TOTAL_INDEX)) begin
            state_d = lts_pkg::ST_TOTAL;
          end else if (req_slot_ok) begin
            state_d = lts_pkg::ST_SLOT_RD;
          end else begin
            state_d = lts_pkg::ST_RESP;
          end
        end
      end
      lts_pkg::ST_PKT:   state_d = lts_pkg::ST_PBYTE;
      lts_pkg::ST_PBYTE: state_d = lts_pkg::ST_SEARCH;
      lts_pkg::ST_SEARCH: begin
        priority if (match) begin
          state_d = lts_pkg::ST_HIT_CNT;
        end else if (!iss_vld_q && (scan_q >= used_q)) begin
          state_d = lts_pkg::ST_MISS;
        end
      end
      lts_pkg::ST_HIT_CNT: state_d = lts_pkg::ST_HIT_BYTE;
      lts_pkg::ST_HIT_BYTE,
      lts_pkg::ST_MISS: begin
        // destination lookup follows the source lookup
        state_d = (!phase_q && dst_lb) ? lts_pkg::ST_SEARCH : lts_pkg::ST_RESP;
      end
      lts_pkg::ST_TOTAL:     state_d = (k_q == 3'd7) ? lts_pkg::ST_RESP : lts_pkg::ST_TOTAL;
      lts_pkg::ST_SLOT_RD:   state_d = lts_pkg::ST_SLOT_WAIT;
      lts_pkg::ST_SLOT_WAIT: state_d = lts_pkg::ST_RESP;
      lts_pkg::ST_RESP:      state_d = can_send ? lts_pkg::ST_IDLE : lts_pkg::ST_RESP;
      default:               state_d = lts_pkg::ST_IDLE;
    endcase
  end

  // datapath controls: shared adder operands, memory port
  always_comb begin
    add_a     = '0;
    add_b     = '0;
    rd_idx    = scan_q[IdxW-1:0];
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_widx  = hit_idx_q;
    mem_wdata = entry_q;
    unique case (state_q)
      lts_pkg::ST_PKT: begin
        add_a = 48'(pkt_q[cls_q]);
        add_b = 48'd1;
      end
      lts_pkg::ST_PBYTE: begin
        add_a = byte_q[cls_q];
        add_b = 48'(len_q);
      end
      lts_pkg::ST_SEARCH: begin
        issue = scan_q < used_q;
      end
      lts_pkg::ST_HIT_CNT: begin
        add_a = 48'(phase_q ? entry_q.dst_hits : entry_q.src_hits);
        add_b = 48'd1;
      end
      lts_pkg::ST_HIT_BYTE: begin
        add_a                = entry_q.byte_count;
        add_b                = 48'(len_q);
        mem_we               = 1'b1;
        mem_wdata.byte_count = add_sum;
      end
      lts_pkg::ST_MISS: begin
        mem_we               = !full;
        mem_widx             = used_q[IdxW-1:0];
        mem_wdata.addr       = key;
        mem_wdata.src_hits   = phase_q ? 32'd0 : 32'd1;
        mem_wdata.dst_hits   = phase_q ? 32'd1 : 32'd0;
        mem_wdata.byte_count = 48'(len_q);
      end
      lts_pkg::ST_TOTAL: begin
        // packets in the first four steps, bytes in the last four
        add_a = k_q[2] ? res_q.read_bytes : 48'(res_q.read_count_a);
        add_b = k_q[2] ? byte_q[k_q[1:0]] : 48'(pkt_q[k_q[1:0]]);
      end
      lts_pkg::ST_SLOT_RD: begin
        rd_idx = slot_idx;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lts_pkg::ST_IDLE;
      used_q      <= '0;
      max_q       <= lts_pkg::MAX_ENTRIES_RESET;
      phase_q     <= 1'b0;
      scan_q      <= '0;
      iss_vld_q   <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pkt_q[i]  <= '0;
        byte_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      iss_vld_q <= issue;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      scan_q <= (state_q == lts_pkg::ST_SEARCH) ? scan_q + CntW'(issue) : '0;
      k_q    <= (state_q == lts_pkg::ST_TOTAL) ? k_q + 3'd1 : 3'd0;
      if (state_q == lts_pkg::ST_PKT) begin
        pkt_q[cls_q] <= add_sum[31:0];
      end
      if (state_q == lts_pkg::ST_PBYTE) begin
        byte_q[cls_q] <= add_sum;
        phase_q       <= !src_lb;
      end
      if ((state_q == lts_pkg::ST_HIT_BYTE) || (state_q == lts_pkg::ST_MISS)) begin
        if (!phase_q && dst_lb) begin
          phase_q <= 1'b1;
        end
      end
      if ((state_q == lts_pkg::ST_MISS) && !full) begin
        used_q <= used_q + CntW'(1);
      end
      if ((state_q == lts_pkg::ST_RESP) && can_send) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lts_pkg::ST_IDLE: begin
        if (accept) begin
          src_q <= req_i.src_addr;
          dst_q <= req_i.dst_addr;
          len_q <= req_i.pkt_len;
          cls_q <= lts_pkg::classify(req_i.protocol);
          idx_q <= req_i.read_index;
          res_q <= res_init;
        end
      end
      lts_pkg::ST_SEARCH: begin
        if (match) begin
          entry_q   <= rd_q;
          hit_idx_q <= iss_idx_q;
        end
      end
      lts_pkg::ST_HIT_CNT: begin
        if (phase_q) begin
          entry_q.dst_hits <= add_sum[31:0];
        end else begin
          entry_q.src_hits <= add_sum[31:0];
        end
      end
      lts_pkg::ST_MISS: begin
        if (full) begin
          res_q.address_dropped <= 1'b1;
        end
      end
      lts_pkg::ST_TOTAL: begin
        if (k_q[2]) begin
          res_q.read_bytes <= add_sum;
        end else begin
          res_q.read_count_a <= add_sum[31:0];
        end
      end
      lts_pkg::ST_SLOT_WAIT: begin
        res_q.read_addr    <= rd_q.addr;
        res_q.read_count_a <= rd_q.src_hits;
        res_q.read_count_b <= rd_q.dst_hits;
        res_q.read_bytes   <= rd_q.byte_count;
      end
      lts_pkg::ST_RESP: begin
        if (can_send) begin
          out_q <= res_fin;
        end
      end
      default: ;
    endcase
    if (issue) begin
      iss_idx_q <= scan_q[IdxW-1:0];
    end
  end

  // address table, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_widx] <= mem_wdata;
    end
    rd_q <= slot_mem_q[rd_idx];
  end

  assign req_i.ready           = (state_q == lts_pkg::ST_IDLE);
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.proto_class     = out_q.proto_class;
  assign rsp_o.address_dropped = out_q.address_dropped;
  assign rsp_o.entries_in_use  = out_q.entries_in_use;
  assign rsp_o.read_addr       = out_q.read_addr;
  assign rsp_o.read_count_a    = out_q.read_count_a;
  assign rsp_o.read_count_b    = out_q.read_count_b;
  assign rsp_o.read_bytes      = out_q.read_bytes;

endmodule

// File: design/lts_checker.sv
module lts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic [1:0]  rsp_proto_class_i,
  input logic        rsp_address_dropped_i,
  input logic [31:0] rsp_read_addr_i,
  input logic [31:0] rsp_read_count_a_i,
  input logic [31:0] rsp_read_count_b_i,
  input logic [47:0] rsp_read_bytes_i
);

  // response stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response withdrawn before it was taken");

  // the block works on one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is still being worked on");

  // an ignored packet carries no class and no drop flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == lts_pkg::STAT_IGNORED) |->
      (rsp_proto_class_i == 2'd0) && !rsp_address_dropped_i)
    else $error("ignored packet reports a class or a drop");

  // a rejected read returns zero read fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == lts_pkg::STAT_READ_BAD) |->
      (rsp_read_addr_i == 32'd0) && (rsp_read_count_a_i == 32'd0) &&
      (rsp_read_count_b_i == 32'd0) && (rsp_read_bytes_i == 48'd0))
    else $error("invalid read returned data");

endmodule

bind loopback_traffic_stats_table_top lts_checker u_lts_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .req_valid_i           (req_i.valid),
  .req_ready_i           (req_i.ready),
  .rsp_valid_i           (rsp_o.valid),
  .rsp_ready_i           (rsp_o.ready),
  .rsp_status_i          (rsp_o.status),
  .rsp_proto_class_i     (rsp_o.proto_class),
  .rsp_address_dropped_i (rsp_o.address_dropped),
  .rsp_read_addr_i       (rsp_o.read_addr),
  .rsp_read_count_a_i    (rsp_o.read_count_a),
  .rsp_read_count_b_i    (rsp_o.read_count_b),
  .rsp_read_bytes_i      (rsp_o.read_bytes)
);
